/* sv/pnl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnl_pkg
// Shared types, register map and saturation helpers for the neighbor list.
// ----------------------------------------------------------------------------
package pnl_pkg;

    // displacement, held to +-2^34
    typedef logic signed [35:0] t_disp;
    // rounded wrap quotient, held to +-2^31
    typedef logic signed [32:0] t_quot;

    typedef enum logic [2:0] {
        REG_ATOM_COUNT = 3'd0,
        REG_CUTOFF     = 3'd1,
        REG_BOX_AX     = 3'd2,
        REG_BOX_BX     = 3'd3,
        REG_BOX_BY     = 3'd4,
        REG_BOX_CX     = 3'd5,
        REG_BOX_CY     = 3'd6,
        REG_BOX_CZ     = 3'd7
    } t_reg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // wrap step: box vector c, then b, then a
    typedef enum logic [2:0] {
        STEP_C = 3'b001,
        STEP_B = 3'b010,
        STEP_A = 3'b100
    } t_step;

    function automatic t_disp sat_disp(input logic signed [66:0] v);
        if (v > 67'sh4_0000_0000) begin
            return 36'sh4_0000_0000;
        end else if (v < -(67'sh4_0000_0000)) begin
            return 36'shC_0000_0000;
        end
        return 36'(v);
    endfunction

    function automatic t_quot sat_quot(input logic signed [38:0] v);
        if (v > 39'sh0_8000_0000) begin
            return 33'sh0_8000_0000;
        end else if (v < -(39'sh0_8000_0000)) begin
            return 33'sh1_8000_0000;
        end
        return 33'(v);
    endfunction

    function automatic logic [34:0] abs_disp(input t_disp v);
        if (v < 0) begin
            return 35'(-v);
        end
        return 35'(v);
    endfunction

endpackage

/* sv/pnl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pnl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/periodic_neighbor_list.sv */
`timescale 1ns / 1ps
// Operation: a load finishes in its accept cycle and gives no result. A query first reads
//   the center row, then for each scanned atom forms the difference, wraps it (when the box
//   is set) by the c, b and a steps, each a bit-serial divide and a multiply and subtract
//   per component, drops it if a component lies beyond the cutoff, else sums the squares.
// Transactions: one at a time; each result passes the emit state and waits out
//   output stalls in a one-entry register. Reset clears control and config, not the store.
// ----------------------------------------------------------------------------
// periodic_neighbor_list
// Brute-force neighbor search over a position RAM with triclinic minimum image.
// ----------------------------------------------------------------------------
module periodic_neighbor_list #(
    parameter int MAX_ATOMS     = 1024,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [9:0]  i_atom_index,
    input  logic signed [31:0] i_pos_x_in,
    input  logic signed [31:0] i_pos_y_in,
    input  logic signed [31:0] i_pos_z_in,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_neighbor_index,
    output logic        o_found,
    output logic        o_last,
    output logic        o_truncated
);

    localparam int AW   = $clog2(MAX_ATOMS);
    localparam int CW   = $clog2(MAX_ATOMS + 1);
    localparam int NW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int DIVN = 37;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CRD  = 13'b0000000000010,
        S_ADDR = 13'b0000000000100,
        S_DIFF = 13'b0000000001000,
        S_DIVI = 13'b0000000010000,
        S_DIV  = 13'b0000000100000,
        S_QFIX = 13'b0000001000000,
        S_MUL  = 13'b0000010000000,
        S_SUB  = 13'b0000100000000,
        S_CHK  = 13'b0001000000000,
        S_SQ   = 13'b0010000000000,
        S_ACC  = 13'b0100000000000,
        S_EMIT = 13'b1000000000000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0]        r_atom_count;
    logic [30:0]        r_cutoff;
    logic [30:0]        r_box_ax;
    logic signed [31:0] r_box_bx;
    logic [30:0]        r_box_by;
    logic signed [31:0] r_box_cx;
    logic signed [31:0] r_box_cy;
    logic [30:0]        r_box_cz;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count <= '0;
            r_cutoff     <= '0;
            r_box_ax     <= '0;
            r_box_bx     <= '0;
            r_box_by     <= '0;
            r_box_cx     <= '0;
            r_box_cy     <= '0;
            r_box_cz     <= '0;
        end else if (cfg_wr) begin
            case (pnl_pkg::t_reg'(paddr[4:2]))
                pnl_pkg::REG_ATOM_COUNT: r_atom_count <= pwdata[10:0];
                pnl_pkg::REG_CUTOFF:     r_cutoff     <= pwdata[30:0];
                pnl_pkg::REG_BOX_AX:     r_box_ax     <= pwdata[30:0];
                pnl_pkg::REG_BOX_BX:     r_box_bx     <= pwdata;
                pnl_pkg::REG_BOX_BY:     r_box_by     <= pwdata[30:0];
                pnl_pkg::REG_BOX_CX:     r_box_cx     <= pwdata;
                pnl_pkg::REG_BOX_CY:     r_box_cy     <= pwdata;
                pnl_pkg::REG_BOX_CZ:     r_box_cz     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extending the unsigned registers
    always_comb begin
        case (pnl_pkg::t_reg'(paddr[4:2]))
            pnl_pkg::REG_ATOM_COUNT: prdata = {21'd0, r_atom_count};
            pnl_pkg::REG_CUTOFF:     prdata = {1'b0, r_cutoff};
            pnl_pkg::REG_BOX_AX:     prdata = {1'b0, r_box_ax};
            pnl_pkg::REG_BOX_BX:     prdata = r_box_bx;
            pnl_pkg::REG_BOX_BY:     prdata = {1'b0, r_box_by};
            pnl_pkg::REG_BOX_CX:     prdata = r_box_cx;
            pnl_pkg::REG_BOX_CY:     prdata = r_box_cy;
            pnl_pkg::REG_BOX_CZ:     prdata = {1'b0, r_box_cz};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Position store: one RAM row holds {z, y, x}
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CW-1:0]      r_j, n_j;
    logic [95:0]        ram_rdata;
    logic [AW-1:0]      ram_raddr;
    logic               ram_we;
    logic               idx_ok;
    logic signed [31:0] ram_x, ram_y, ram_z;

    assign idx_ok    = 32'(i_atom_index) < 32'(MAX_ATOMS);
    assign ram_we    = (r_state == S_IDLE) && i_in_valid && idx_ok
                       && (i_cmd == pnl_pkg::CMD_LOAD);
    // in idle, address the incoming atom; during a scan, the candidate
    assign ram_raddr = (r_state == S_IDLE) ? AW'(i_atom_index) : r_j[AW-1:0];
    assign ram_x     = $signed(ram_rdata[31:0]);
    assign ram_y     = $signed(ram_rdata[63:32]);
    assign ram_z     = $signed(ram_rdata[95:64]);

    pnl_ram #(
        .WIDTH (96),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_atom_index)),
        .i_wdata ({i_pos_z_in, i_pos_y_in, i_pos_x_in}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Query sequencer
    // ------------------------------------------------------------------
    logic [AW-1:0]      r_ctr, n_ctr;
    logic signed [31:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [CW-1:0]      r_count, n_count;
    pnl_pkg::t_disp     r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    pnl_pkg::t_step     r_step, n_step;
    logic [1:0]         r_comp, n_comp;
    logic [31:0]        r_m, n_m;
    logic [DIVN-1:0]    r_qd, n_qd;
    logic [31:0]        r_rem, n_rem;
    logic [5:0]         r_dcnt, n_dcnt;
    logic               r_neg, n_neg;
    pnl_pkg::t_quot     r_q, n_q;
    logic signed [64:0] r_prod, n_prod;
    logic [63:0]        r_acc, n_acc;
    logic               r_have, n_have;
    logic [9:0]         r_pend, n_pend;
    logic [NW-1:0]      r_n, n_n;
    logic [9:0]         r_e_idx, n_e_idx;
    logic               r_e_found, n_e_found;
    logic               r_e_last, n_e_last;
    logic               r_e_trunc, n_e_trunc;
    logic               r_out_valid, n_out_valid;
    logic [9:0]         r_o_idx, n_o_idx;
    logic               r_o_found, n_o_found;
    logic               r_o_last, n_o_last;
    logic               r_o_trunc, n_o_trunc;

    // divider datapath: n = 2d + L, m = 2L, one quotient bit per cycle
    pnl_pkg::t_disp     d_sel;
    logic [30:0]        l_sel;
    logic signed [37:0] div_num;
    logic [DIVN-1:0]    div_abs;
    logic [32:0]        div_sh;
    logic [32:0]        div_sub;
    logic               div_ge;
    logic signed [38:0] q_wide;

    always_comb begin
        case (r_step)
            pnl_pkg::STEP_C: begin d_sel = r_dz; l_sel = r_box_cz; end
            pnl_pkg::STEP_B: begin d_sel = r_dy; l_sel = r_box_by; end
            default:         begin d_sel = r_dx; l_sel = r_box_ax; end
        endcase
    end

    assign div_num = (38'(d_sel) <<< 1) + $signed({7'd0, l_sel});
    assign div_abs = div_num[37] ? DIVN'(-div_num) : DIVN'(div_num);
    assign div_sh  = {r_rem, r_qd[DIVN-1]};
    assign div_ge  = div_sh >= {1'b0, r_m};
    assign div_sub = div_sh - {1'b0, r_m};
    // floor for negative numerators: step down when the remainder is nonzero
    assign q_wide  = r_neg ? -$signed(39'(r_qd) + 39'(r_rem != '0))
                           : $signed(39'(r_qd));

    // shared multiplier: wrap products, then the squares and cutoff^2
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;
    logic [34:0]        abs_sel;
    pnl_pkg::t_disp     d_cur;
    logic [1:0]         comp_last;
    logic [34:0]        ax_abs, ay_abs, az_abs;

    assign ax_abs = pnl_pkg::abs_disp(r_dx);
    assign ay_abs = pnl_pkg::abs_disp(r_dy);
    assign az_abs = pnl_pkg::abs_disp(r_dz);

    always_comb begin
        case (r_comp)
            2'd0:    begin abs_sel = ax_abs; d_cur = r_dx; end
            2'd1:    begin abs_sel = ay_abs; d_cur = r_dy; end
            default: begin abs_sel = az_abs; d_cur = r_dz; end
        endcase
    end

    always_comb begin
        case (r_step)
            pnl_pkg::STEP_C: comp_last = 2'd2;
            pnl_pkg::STEP_B: comp_last = 2'd1;
            default:         comp_last = 2'd0;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            mul_b = r_q;
            case (r_step)
                pnl_pkg::STEP_C: begin
                    case (r_comp)
                        2'd0:    mul_a = r_box_cx;
                        2'd1:    mul_a = r_box_cy;
                        default: mul_a = $signed({1'b0, r_box_cz});
                    endcase
                end
                pnl_pkg::STEP_B: begin
                    mul_a = (r_comp == 2'd0) ? r_box_bx : $signed({1'b0, r_box_by});
                end
                default: mul_a = $signed({1'b0, r_box_ax});
            endcase
        end else if (r_state == S_SQ) begin
            // components already passed the far check, so they fit in 31 bits
            if (r_comp == 2'd3) begin
                mul_a = $signed({1'b0, r_cutoff});
                mul_b = $signed({2'b00, r_cutoff});
            end else begin
                mul_a = $signed({1'b0, abs_sel[30:0]});
                mul_b = $signed({2'b00, abs_sel[30:0]});
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    logic out_free;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_ctr       = r_ctr;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_count     = r_count;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dz        = r_dz;
        n_step      = r_step;
        n_comp      = r_comp;
        n_m         = r_m;
        n_qd        = r_qd;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_neg       = r_neg;
        n_q         = r_q;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_have      = r_have;
        n_pend      = r_pend;
        n_n         = r_n;
        n_e_idx     = r_e_idx;
        n_e_found   = r_e_found;
        n_e_last    = r_e_last;
        n_e_trunc   = r_e_trunc;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_idx     = r_o_idx;
        n_o_found   = r_o_found;
        n_o_last    = r_o_last;
        n_o_trunc   = r_o_trunc;

        case (r_state)
            S_IDLE: begin
                // loads finish here; queries start a scan, or report not-found for an index out of range
                if (i_in_valid && (i_cmd == pnl_pkg::CMD_QUERY)) begin
                    n_have = 1'b0;
                    n_n    = '0;
                    n_ctr  = AW'(i_atom_index);
                    n_count = (32'(r_atom_count) > 32'(MAX_ATOMS))
                              ? CW'(MAX_ATOMS) : CW'(r_atom_count);
                    if (idx_ok) begin
                        n_state = S_CRD;
                    end else begin
                        n_e_idx   = '0;
                        n_e_found = 1'b0;
                        n_e_last  = 1'b1;
                        n_e_trunc = 1'b0;
                        n_state   = S_EMIT;
                    end
                end
            end
            S_CRD: begin
                // center row arrives
                n_cx    = ram_x;
                n_cy    = ram_y;
                n_cz    = ram_z;
                n_j     = '0;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                if (r_j >= r_count) begin
                    // end of scan: flush the held neighbor or report none
                    n_e_idx   = r_have ? r_pend : '0;
                    n_e_found = r_have;
                    n_e_last  = 1'b1;
                    n_e_trunc = 1'b0;
                    n_state   = S_EMIT;
                end else if (r_j == CW'(r_ctr)) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_dx = 36'(ram_x) - 36'(r_cx);
                n_dy = 36'(ram_y) - 36'(r_cy);
                n_dz = 36'(ram_z) - 36'(r_cz);
                if (r_box_ax == '0) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_DIVI;
                    if (r_box_cz != '0) begin
                        n_step = pnl_pkg::STEP_C;
                    end else if (r_box_by != '0) begin
                        n_step = pnl_pkg::STEP_B;
                    end else begin
                        n_step = pnl_pkg::STEP_A;
                    end
                end
            end
            S_DIVI: begin
                n_m     = {l_sel, 1'b0};
                n_qd    = div_abs;
                n_neg   = div_num[37];
                n_rem   = '0;
                n_dcnt  = 6'(DIVN - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? div_sub[31:0] : div_sh[31:0];
                n_qd  = {r_qd[DIVN-2:0], div_ge};
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    n_state = S_QFIX;
                end
            end
            S_QFIX: begin
                n_q     = pnl_pkg::sat_quot(q_wide);
                n_comp  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_SUB;
            end
            S_SUB: begin
                case (r_comp)
                    2'd0:    n_dx = pnl_pkg::sat_disp(67'(d_cur) - 67'(r_prod));
                    2'd1:    n_dy = pnl_pkg::sat_disp(67'(d_cur) - 67'(r_prod));
                    default: n_dz = pnl_pkg::sat_disp(67'(d_cur) - 67'(r_prod));
                endcase
                if (r_comp != comp_last) begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_MUL;
                end else begin
                    case (r_step)
                        pnl_pkg::STEP_C: begin
                            n_step  = (r_box_by != '0) ? pnl_pkg::STEP_B
                                                       : pnl_pkg::STEP_A;
                            n_state = S_DIVI;
                        end
                        pnl_pkg::STEP_B: begin
                            n_step  = pnl_pkg::STEP_A;
                            n_state = S_DIVI;
                        end
                        default: n_state = S_CHK;
                    endcase
                end
            end
            S_CHK: begin
                // drop far atoms before squaring
                n_acc  = '0;
                n_comp = '0;
                if (ax_abs > {4'd0, r_cutoff} || ay_abs > {4'd0, r_cutoff}
                    || az_abs > {4'd0, r_cutoff}) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_ADDR;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_prod  = mul_p;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_comp != 2'd3) begin
                    n_acc   = r_acc + 64'(r_prod);
                    n_comp  = r_comp + 1'b1;
                    n_state = S_SQ;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_ADDR;
                    if (r_acc <= 64'(r_prod)) begin
                        if (!r_have) begin
                            // hold the first hit until we know if it is final
                            n_have = 1'b1;
                            n_pend = 10'(r_j);
                            n_n    = NW'(1);
                        end else if (r_n == NW'(MAX_NEIGHBORS)) begin
                            n_e_idx   = r_pend;
                            n_e_found = 1'b1;
                            n_e_last  = 1'b1;
                            n_e_trunc = 1'b1;
                            n_state   = S_EMIT;
                        end else begin
                            n_e_idx   = r_pend;
                            n_e_found = 1'b1;
                            n_e_last  = 1'b0;
                            n_e_trunc = 1'b0;
                            n_pend    = 10'(r_j);
                            n_n       = r_n + 1'b1;
                            n_state   = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_idx     = r_e_idx;
                    n_o_found   = r_e_found;
                    n_o_last    = r_e_last;
                    n_o_trunc   = r_e_trunc;
                    n_state     = r_e_last ? S_IDLE : S_ADDR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_n         <= '0;
            r_j         <= '0;
            r_step      <= pnl_pkg::STEP_A;
            r_comp      <= '0;
            r_dcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_n         <= n_n;
            r_j         <= n_j;
            r_step      <= n_step;
            r_comp      <= n_comp;
            r_dcnt      <= n_dcnt;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_ctr     <= n_ctr;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_cz      <= n_cz;
        r_count   <= n_count;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dz      <= n_dz;
        r_m       <= n_m;
        r_qd      <= n_qd;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_q       <= n_q;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_pend    <= n_pend;
        r_e_idx   <= n_e_idx;
        r_e_found <= n_e_found;
        r_e_last  <= n_e_last;
        r_e_trunc <= n_e_trunc;
        r_o_idx   <= n_o_idx;
        r_o_found <= n_o_found;
        r_o_last  <= n_o_last;
        r_o_trunc <= n_o_trunc;
    end

    assign o_out_valid      = r_out_valid;
    assign o_neighbor_index = r_o_idx;
    assign o_found          = r_o_found;
    assign o_last           = r_o_last;
    assign o_truncated      = r_o_trunc;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_notfound_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && !o_truncated)
        else $error("not-found result must be final and untruncated");

    a_trunc_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_last && o_found)
        else $error("truncated flag only on a final found result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_n) <= 32'(MAX_NEIGHBORS))
        else $error("neighbor count beyond limit");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && out_free |=> o_out_valid)
        else $error("emitted result not presented");

endmodule
